// File: hdl/pidpwm_pkg.sv
// ----------------------------------------------------------------------------
// pidpwm_pkg
// Types, register indexes and constants used by the PID position
// controller.
// ----------------------------------------------------------------------------
package pidpwm_pkg;

  // Number of motor channels with their own integral and error state.
  localparam int unsigned CHANNELS_DEF = 4;

  // Width of the configuration data bus (widest register).
  localparam int unsigned CFG_DW = 32;
  localparam int unsigned CFG_AW = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_AW-1:0] {
    REG_PROP_GAIN_A  = 3'd0,
    REG_INTEG_GAIN_A = 3'd1,
    REG_DERIV_GAIN_A = 3'd2,
    REG_PROP_GAIN_B  = 3'd3,
    REG_INTEG_GAIN_B = 3'd4,
    REG_DERIV_GAIN_B = 3'd5,
    REG_STOP_TOL     = 3'd6
  } cfg_reg_e;

  // Register values after reset.
  localparam logic [31:0] PROP_GAIN_A_RST  = 32'd8589935;
  localparam logic [31:0] INTEG_GAIN_A_RST = 32'd85899;
  localparam logic [31:0] DERIV_GAIN_A_RST = 32'd429497;
  localparam logic [31:0] PROP_GAIN_B_RST  = 32'd2147484;
  localparam logic [31:0] INTEG_GAIN_B_RST = 32'd4295;
  localparam logic [31:0] DERIV_GAIN_B_RST = 32'd4294967;
  localparam logic [15:0] STOP_TOL_RST     = 16'd1000;

  // PWM compare values.
  localparam logic [8:0] PWM_MID  = 9'd300;
  localparam logic [8:0] PWM_HIGH = 9'd400;
  localparam logic [8:0] PWM_LOW  = 9'd200;

  typedef struct packed {
    logic [1:0]         channel;
    logic signed [31:0] target_position;
    logic signed [31:0] encoder_count;
  } in_item_t;

  typedef struct packed {
    logic [8:0] pwm_compare;
    logic       at_target;
  } out_item_t;

endpackage

// File: hdl/pidpwm_ram.sv
// ----------------------------------------------------------------------------
// pidpwm_ram
// Generic single-clock RAM with one write port and one registered read port.
// A read and a write of the same address in one cycle return the old data.
// ----------------------------------------------------------------------------
module pidpwm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/pid_position_pwm_controller.sv
// ----------------------------------------------------------------------------
// pid_position_pwm_controller
// PID position controller with a stop band, one motor channel per transaction.
//
// Input channel (in_valid_i / in_ready_o / in_item_i): one control tick, giving
// the channel, the target position and the encoder count. Output channel
// (out_valid_o / out_ready_i / out_item_o): one PWM compare value and an
// at-target flag per input transaction, in input order.
// The per-channel integral and previous error live in one small RAM that is
// read when a transaction is accepted and written back as it leaves stage 1,
// with forwarding when consecutive ticks hit the same channel.
// Results pass stages 1 to 4 and an output register. Throughput: one
// transaction per cycle without stalls, set by the single read and single
// write port of the state RAM; the three gain multiplies take one stage.
// Reset clears the gains and tolerance to their defaults and marks every
// channel's state as zero through per-entry valid bits; transactions are
// accepted in the first cycle after reset. When the receiver stalls, the
// pipeline keeps filling its empty stages, so input transactions are taken
// until every stage holds one; nothing is dropped.
// Configuration writes are taken at any time and must occur while idle.
// ----------------------------------------------------------------------------
module pid_position_pwm_controller
  import pidpwm_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_item_t          in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_item_o
);

  localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned SW = 65;  // integral (32) and last error (33)
  localparam logic signed [35:0] UP_LIM = 36'(PWM_HIGH - PWM_MID);
  localparam logic signed [35:0] DN_LIM = -36'(PWM_MID - PWM_LOW);

  // ---------------------------------------------------------------- config
  logic [31:0] prop_gain_a_q, integ_gain_a_q, deriv_gain_a_q;
  logic [31:0] prop_gain_b_q, integ_gain_b_q, deriv_gain_b_q;
  logic [15:0] stop_tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_a_q  <= PROP_GAIN_A_RST;
      integ_gain_a_q <= INTEG_GAIN_A_RST;
      deriv_gain_a_q <= DERIV_GAIN_A_RST;
      prop_gain_b_q  <= PROP_GAIN_B_RST;
      integ_gain_b_q <= INTEG_GAIN_B_RST;
      deriv_gain_b_q <= DERIV_GAIN_B_RST;
      stop_tol_q     <= STOP_TOL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PROP_GAIN_A:  prop_gain_a_q  <= cfg_data_i;
        REG_INTEG_GAIN_A: integ_gain_a_q <= cfg_data_i;
        REG_DERIV_GAIN_A: deriv_gain_a_q <= cfg_data_i;
        REG_PROP_GAIN_B:  prop_gain_b_q  <= cfg_data_i;
        REG_INTEG_GAIN_B: integ_gain_b_q <= cfg_data_i;
        REG_DERIV_GAIN_B: deriv_gain_b_q <= cfg_data_i;
        REG_STOP_TOL:     stop_tol_q     <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- flow control
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, out_valid_q;
  logic rdy_out, rdy4, rdy3, rdy2, rdy1;
  logic accept, s1_adv;

  assign rdy_out = !out_valid_q || out_ready_i;
  assign rdy4    = !s4_valid_q || rdy_out;
  assign rdy3    = !s3_valid_q || rdy4;
  assign rdy2    = !s2_valid_q || rdy3;
  assign rdy1    = !s1_valid_q || rdy2;
  assign accept  = in_valid_i && rdy1;
  assign s1_adv  = s1_valid_q && rdy2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rdy1)    s1_valid_q  <= in_valid_i;
      if (rdy2)    s2_valid_q  <= s1_valid_q;
      if (rdy3)    s3_valid_q  <= s2_valid_q;
      if (rdy4)    s4_valid_q  <= s3_valid_q;
      if (rdy_out) out_valid_q <= s4_valid_q;
    end
  end

  assign in_ready_o  = rdy1;
  assign out_valid_o = out_valid_q;

  // ------------------------------------------------- channel to state index
  logic [4:0]    ch_red;
  logic [AW-1:0] in_idx;

  // The channel field is two bits wide, so three conditional subtractions
  // reduce it modulo any channel count.
  always_comb begin
    ch_red = {3'b000, in_item_i.channel};
    for (int k = 0; k < 3; k++) begin
      if (ch_red >= 5'(CHANNELS)) begin
        ch_red = ch_red - 5'(CHANNELS);
      end
    end
    in_idx = ch_red[AW-1:0];
  end

  // ------------------------------------------------------------ state RAM
  logic [SW-1:0]       ram_rdata;
  logic [SW-1:0]       wb_d;
  logic [SW-1:0]       wb_q;
  logic [CHANNELS-1:0] ent_vld_q;
  logic                fwd_q;
  logic                rd_vld_q;
  logic [AW-1:0]       s1_idx_q;
  logic [1:0]          s1_ch_q;
  logic signed [31:0]  s1_tgt_q, s1_enc_q;

  pidpwm_ram #(
    .WIDTH (SW),
    .DEPTH (CHANNELS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .re_i    (accept),
    .raddr_i (in_idx),
    .rdata_o (ram_rdata),
    .we_i    (s1_adv),
    .waddr_i (s1_idx_q),
    .wdata_i (wb_d)
  );

  // Entries that were never written since reset read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
      fwd_q     <= 1'b0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (s1_adv) begin
        ent_vld_q[s1_idx_q] <= 1'b1;
      end
      if (accept) begin
        // The write-back of the item leaving stage 1 lands on the same edge
        // as this read, so the RAM would return stale data for that entry.
        fwd_q    <= s1_adv && (s1_idx_q == in_idx);
        rd_vld_q <= ent_vld_q[in_idx];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_idx_q <= in_idx;
      s1_ch_q  <= in_item_i.channel;
      s1_tgt_q <= in_item_i.target_position;
      s1_enc_q <= in_item_i.encoder_count;
    end
    if (s1_adv) begin
      wb_q <= wb_d;
    end
  end

  // ------------------------------------------- stage 1: read, modify, write
  logic [SW-1:0]      st_cur;
  logic signed [31:0] integ_old, integ_new;
  logic signed [32:0] last_old, err;
  logic signed [33:0] integ_sum, deriv;
  logic [32:0]        err_mag;
  logic               stop;

  always_comb begin
    if (fwd_q) begin
      st_cur = wb_q;
    end else if (rd_vld_q) begin
      st_cur = ram_rdata;
    end else begin
      st_cur = '0;
    end
    integ_old = st_cur[64:33];
    last_old  = st_cur[32:0];
    err       = {s1_tgt_q[31], s1_tgt_q} - {s1_enc_q[31], s1_enc_q};
    integ_sum = {{2{integ_old[31]}}, integ_old} + {err[32], err};
    // Hold the integral when the sum leaves the signed 32-bit range.
    if (integ_sum[33:31] == 3'b000 || integ_sum[33:31] == 3'b111) begin
      integ_new = integ_sum[31:0];
    end else begin
      integ_new = integ_old;
    end
    deriv   = {err[32], err} - {last_old[32], last_old};
    err_mag = err[32] ? 33'(-err) : 33'(err);
    stop    = err_mag < {17'b0, stop_tol_q};
    wb_d    = stop ? '0 : {integ_new, err};
  end

  logic signed [32:0] s2_err_q;
  logic signed [31:0] s2_integ_q;
  logic signed [33:0] s2_deriv_q;
  logic               s2_stop_q, s2_odd_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_err_q   <= err;
      s2_integ_q <= integ_new;
      s2_deriv_q <= deriv;
      s2_stop_q  <= stop;
      s2_odd_q   <= s1_ch_q[0];
    end
  end

  // -------------------------------------------------- stage 2: gain products
  // Each operand is split into an unsigned low word and a small signed high
  // part, so the wide work is three 32x32 unsigned multiplies.
  logic [31:0]        gp, gi, gd;
  logic [63:0]        p0, p1, p2;
  logic signed [33:0] h0, h1;
  logic signed [34:0] h2;
  logic signed [1:0]  d_hi;
  logic signed [32:0] gd_s;

  always_comb begin
    gp   = s2_odd_q ? prop_gain_b_q  : prop_gain_a_q;
    gi   = s2_odd_q ? integ_gain_b_q : integ_gain_a_q;
    gd   = s2_odd_q ? deriv_gain_b_q : deriv_gain_a_q;
    p0   = 64'(s2_err_q[31:0])   * 64'(gp);
    p1   = 64'(s2_integ_q[31:0]) * 64'(gi);
    p2   = 64'(s2_deriv_q[31:0]) * 64'(gd);
    h0   = s2_err_q[32]   ? -$signed({2'b00, gp}) : 34'sd0;
    h1   = s2_integ_q[31] ? -$signed({2'b00, gi}) : 34'sd0;
    d_hi = s2_deriv_q[33:32];
    gd_s = $signed({1'b0, gd});
    h2   = 35'(d_hi) * 35'(gd_s);
  end

  logic [63:0]        s3_p0_q, s3_p1_q, s3_p2_q;
  logic signed [33:0] s3_h0_q, s3_h1_q;
  logic signed [34:0] s3_h2_q;
  logic               s3_stop_q;

  always_ff @(posedge clk_i) begin
    if (s2_valid_q && rdy3) begin
      s3_p0_q   <= p0;
      s3_p1_q   <= p1;
      s3_p2_q   <= p2;
      s3_h0_q   <= h0;
      s3_h1_q   <= h1;
      s3_h2_q   <= h2;
      s3_stop_q <= s2_stop_q;
    end
  end

  // ----------------------------------------------------- stage 3: exact sum
  logic signed [67:0] total;

  always_comb begin
    total = $signed({4'b0000, s3_p0_q})
          + $signed({4'b0000, s3_p1_q})
          + $signed({4'b0000, s3_p2_q})
          + $signed({{2{s3_h0_q[33]}}, s3_h0_q, 32'h0})
          + $signed({{2{s3_h1_q[33]}}, s3_h1_q, 32'h0})
          + $signed({s3_h2_q[34], s3_h2_q, 32'h0});
  end

  logic signed [67:0] s4_total_q;
  logic               s4_stop_q;

  always_ff @(posedge clk_i) begin
    if (s3_valid_q && rdy4) begin
      s4_total_q <= total;
      s4_stop_q  <= s3_stop_q;
    end
  end

  // ------------------------------------- stage 4: truncate, clamp, stop band
  logic signed [35:0] q_floor, q_trunc;
  logic               round_up;
  out_item_t          res;

  always_comb begin
    q_floor  = s4_total_q[67:32];
    // Floor plus one for a negative value with a fraction gives truncation.
    round_up = s4_total_q[67] && (s4_total_q[31:0] != 32'h0);
    q_trunc  = q_floor + 36'(round_up);
    if (s4_stop_q) begin
      res.pwm_compare = PWM_MID;
      res.at_target   = 1'b1;
    end else begin
      res.at_target = 1'b0;
      if (q_trunc > UP_LIM) begin
        res.pwm_compare = PWM_HIGH;
      end else if (q_trunc < DN_LIM) begin
        res.pwm_compare = PWM_LOW;
      end else begin
        res.pwm_compare = PWM_MID + q_trunc[8:0];
      end
    end
  end

  out_item_t out_item_q;

  always_ff @(posedge clk_i) begin
    if (s4_valid_q && rdy_out) begin
      out_item_q <= res;
    end
  end

  assign out_item_o = out_item_q;

endmodule
